[hw/rtl/rctlv_pkg.sv]
// Shared types and constants for the capability report parser.
package rctlv_pkg;

	localparam logic [7:0] TLV_MODES   = 8'd2;
	localparam logic [7:0] TLV_ANTENNA = 8'd10;
	localparam logic [7:0] TLV_RANGE   = 8'd11;
	localparam logic [7:0] MODES_MIN_LEN = 8'd4;
	localparam logic [7:0] RANGE_MIN_LEN = 8'd8;
	localparam logic [7:0] HEAD_BYTES    = 8'd8;

	typedef enum logic [2:0] {
		HDR_TYPE = 3'b001,
		HDR_RSVD = 3'b010,
		HDR_LEN  = 3'b100
	} hdr_t;

	typedef struct packed {
		logic        status;
		logic        valid;
		logic [31:0] mode_mask;
		logic        dome;
		logic [31:0] min_rng;
		logic [31:0] max_rng;
	} rep_t;

endpackage

[hw/rtl/rctlv_div10.sv]
// Divide a 32-bit decimetre value by ten through a reciprocal multiply.
module rctlv_div10
	import rctlv_pkg::*;
(
	input  logic [31:0] dm,
	output logic [28:0] m
);

	localparam logic [31:0] RECIP = 32'hCCCC_CCCD;

	logic [63:0] prod;

	always_comb begin
		prod = 64'(dm) * 64'(RECIP);
		m    = prod[63:35];
	end

endmodule

[hw/rtl/rctlv_parser.sv]
// Byte-wise entry parser holding parse state and the stored capabilities.
module rctlv_parser
	import rctlv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data,
	input  logic       last,
	output rep_t       rep
);

	hdr_t            hdr_q, hdr_n;
	logic            in_pay_q, in_pay_n;
	logic [7:0]      type_q, type_n;
	logic [7:0]      len_q, len_n;
	logic [7:0]      cnt_q, cnt_n;
	logic [7:0][7:0] head_q, head_n;
	logic [31:0]     mask_q, mask_n;
	logic            dome_q, dome_n;
	logic [31:0]     min_q, min_n;
	logic [31:0]     max_q, max_n;
	logic            valid_q, valid_n;
	logic            apply;
	logic            status;

	always_comb begin
		hdr_n    = hdr_q;
		in_pay_n = in_pay_q;
		type_n   = type_q;
		len_n    = len_q;
		cnt_n    = cnt_q;
		head_n   = head_q;
		mask_n   = mask_q;
		dome_n   = dome_q;
		min_n    = min_q;
		max_n    = max_q;
		valid_n  = valid_q;
		apply    = 1'b0;

		if (in_pay_q) begin
			if (cnt_q < HEAD_BYTES) begin
				head_n[cnt_q[2:0]] = data;
			end
			cnt_n = cnt_q + 8'd1;
			if (cnt_n == len_q) begin
				apply    = 1'b1;
				in_pay_n = 1'b0;
				hdr_n    = HDR_TYPE;
			end
		end else begin
			unique case (hdr_q)
				HDR_TYPE: begin
					type_n = data;
					hdr_n  = HDR_RSVD;
				end
				HDR_RSVD: begin
					hdr_n = HDR_LEN;
				end
				HDR_LEN: begin
					len_n  = data;
					cnt_n  = 8'd0;
					head_n = '0;
					hdr_n  = HDR_TYPE;
					if (data == 8'd0) begin
						apply = 1'b1;
					end else begin
						in_pay_n = 1'b1;
					end
				end
				default: begin
					hdr_n = HDR_TYPE;
				end
			endcase
		end

		if (apply) begin
			unique case (type_q)
				TLV_MODES: begin
					if (len_n >= MODES_MIN_LEN) begin
						mask_n = head_n[3:0];
					end
				end
				TLV_ANTENNA: begin
					dome_n = (len_n == 8'd1) && (head_n[0] == 8'd0);
				end
				TLV_RANGE: begin
					if (len_n >= RANGE_MIN_LEN) begin
						min_n = head_n[3:0];
						max_n = head_n[7:4];
					end
				end
				default: begin
				end
			endcase
		end

		status = in_pay_n;
		if (last) begin
			valid_n  = valid_q | ~in_pay_n;
			hdr_n    = HDR_TYPE;
			in_pay_n = 1'b0;
			type_n   = 8'd0;
			len_n    = 8'd0;
			cnt_n    = 8'd0;
			head_n   = '0;
		end

		rep.status    = status;
		rep.valid     = valid_n;
		rep.mode_mask = mask_n;
		rep.dome      = dome_n;
		rep.min_rng   = min_n;
		rep.max_rng   = max_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q    <= HDR_TYPE;
			in_pay_q <= 1'b0;
			type_q   <= 8'd0;
			len_q    <= 8'd0;
			cnt_q    <= 8'd0;
			head_q   <= '0;
			mask_q   <= 32'd0;
			dome_q   <= 1'b0;
			min_q    <= 32'd0;
			max_q    <= 32'd0;
			valid_q  <= 1'b0;
		end else if (take) begin
			hdr_q    <= hdr_n;
			in_pay_q <= in_pay_n;
			type_q   <= type_n;
			len_q    <= len_n;
			cnt_q    <= cnt_n;
			head_q   <= head_n;
			mask_q   <= mask_n;
			dome_q   <= dome_n;
			min_q    <= min_n;
			max_q    <= max_n;
			valid_q  <= valid_n;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		in_pay_q |-> (cnt_q < len_q))
		else $error("payload count reached entry length inside payload");
	a_pay_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		in_pay_q |-> (hdr_q == HDR_TYPE))
		else $error("header position not at type during payload");
	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(valid_q))
		else $error("capabilities valid flag cleared");
`endif

endmodule

[hw/rtl/radar_capability_tlv_parser_core.sv]
// Top level of the capability report TLV parser.
//
// Input channel: in_valid/in_ready carry one report byte per item, with
// last_byte high on the final byte of a report. Bytes are taken one per
// cycle while in_ready is high; each byte only advances the small parse state.
// Output channel: out_valid/out_ready carry one result per report, issued
// for the final byte: status and the stored capabilities (mode mask, dome
// flag, minimum and maximum range in metres).
// After its final byte is taken, a result passes the input register, the
// parse stage, the minimum-range divide stage and the maximum-range
// divide stage into the output register. Each divide stage holds one
// 32 by 32 reciprocal multiply. Sustained rate: one byte per cycle while in_ready is high.
// Reset clears the parse position and all stored capabilities; the first
// result after reset reports capabilities_valid low unless that report
// parsed completely.
// When the receiver stalls, results queue in the stages behind the output
// register; non-final bytes keep flowing until a final byte finds the
// stage after parsing full, and only then is in_ready dropped.
module radar_capability_tlv_parser_core
	import rctlv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  report_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic        capabilities_valid,
	output logic [31:0] use_mode_mask,
	output logic        is_dome,
	output logic [28:0] min_range_meters,
	output logic [28:0] max_range_meters
);

	logic        v_s1_q;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        v_s2_q;
	rep_t        rep_s2;
	logic        v_s3_q;
	rep_t        rep_s3;
	logic        out_valid_q;
	rep_t        rep_q;
	rep_t        rep;
	logic [28:0] min_m;
	logic [28:0] max_m;
	logic        s1_go;
	logic        s2_go;
	logic        s3_go;
	logic        s2_free;
	logic        s3_free;
	logic        out_free;

	always_comb begin
		out_free = !out_valid_q || out_ready;
		s3_go    = v_s3_q && out_free;
		s3_free  = !v_s3_q || s3_go;
		s2_go    = v_s2_q && s3_free;
		s2_free  = !v_s2_q || s2_go;
		s1_go    = v_s1_q && (!last_s1 || s2_free);
		in_ready = !v_s1_q || s1_go;
	end

	rctlv_parser u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (s1_go),
		.data  (byte_s1),
		.last  (last_s1),
		.rep   (rep)
	);

	rctlv_div10 u_div_min (
		.dm(rep_s2.min_rng),
		.m (min_m)
	);

	rctlv_div10 u_div_max (
		.dm(rep_s3.max_rng),
		.m (max_m)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			v_s3_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1_q <= in_valid;
			end
			if (s2_free) begin
				v_s2_q <= s1_go && last_s1;
			end
			if (s3_free) begin
				v_s3_q <= s2_go;
			end
			if (out_free) begin
				out_valid_q <= s3_go;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= report_byte;
			last_s1 <= last_byte;
		end
		if (s2_free && s1_go && last_s1) begin
			rep_s2 <= rep;
		end
		if (s2_go) begin
			rep_s3 <= '{status:    rep_s2.status,
			            valid:     rep_s2.valid,
			            mode_mask: rep_s2.mode_mask,
			            dome:      rep_s2.dome,
			            min_rng:   {3'b000, min_m},
			            max_rng:   rep_s2.max_rng};
		end
		if (s3_go) begin
			rep_q <= '{status:    rep_s3.status,
			           valid:     rep_s3.valid,
			           mode_mask: rep_s3.mode_mask,
			           dome:      rep_s3.dome,
			           min_rng:   rep_s3.min_rng,
			           max_rng:   {3'b000, max_m}};
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = rep_q.status;
	assign capabilities_valid = rep_q.valid;
	assign use_mode_mask      = rep_q.mode_mask;
	assign is_dome            = rep_q.dome;
	assign min_range_meters   = rep_q.min_rng[28:0];
	assign max_range_meters   = rep_q.max_rng[28:0];

`ifndef ASSERT_OFF
	a_last_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> v_s2_q)
		else $error("final item lost between parse and divide stages");
	a_ok_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !status) |-> capabilities_valid)
		else $error("parsed report without valid capabilities");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(rep_q)))
		else $error("result item changed while stalled");
`endif

endmodule

[sim/radar_capability_tlv_parser_core_tb.sv]
// Self-checking testbench for the capability report TLV parser core.
module radar_capability_tlv_parser_core_tb;
	import rctlv_pkg::*;

	localparam int          RAND_BYTES     = 850;
	localparam int          CYCLE_LIMIT    = 400000;
	localparam int          TAIL_CYCLES    = 20;
	localparam int          DECI_PER_METRE = 10;
	localparam logic [28:0] RANGE_TOP      = 29'd429496729;

	typedef struct packed {
		logic        status;
		logic        caps_valid;
		logic [31:0] mode_mask;
		logic        dome;
		logic [28:0] min_m;
		logic [28:0] max_m;
	} caps_report_t;

	typedef struct packed {
		logic [7:0]   data;
		logic         fin;
		logic         typed;
		caps_report_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  report_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic        status;
	logic        capabilities_valid;
	logic [31:0] use_mode_mask;
	logic        is_dome;
	logic [28:0] min_range_meters;
	logic [28:0] max_range_meters;

	radar_capability_tlv_parser_core u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.report_byte        (report_byte),
		.last_byte          (last_byte),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.status             (status),
		.capabilities_valid (capabilities_valid),
		.use_mode_mask      (use_mode_mask),
		.is_dome            (is_dome),
		.min_range_meters   (min_range_meters),
		.max_range_meters   (max_range_meters)
	);

	// parser state mirrored from the block
	hdr_t        hdr_pos;
	logic        in_pay;
	logic [7:0]  ent_type;
	logic [7:0]  ent_len;
	logic [7:0]  pay_cnt;
	logic [63:0] pay_head;
	logic [31:0] mask_q;
	logic        dome_q;
	logic [28:0] min_q;
	logic [28:0] max_q;
	logic        caps_ok;

	caps_report_t expected_caps[$];
	dir_row_t     dir_steps[$];
	logic [7:0]   rpt_bytes[$];
	int           n_errs;

	function automatic void clear_parse();
		hdr_pos  = HDR_TYPE;
		in_pay   = 1'b0;
		ent_type = '0;
		ent_len  = '0;
		pay_cnt  = '0;
		pay_head = '0;
	endfunction

	function automatic void commit_entry();
		if (ent_type == TLV_MODES) begin
			if (ent_len >= MODES_MIN_LEN)
				mask_q = pay_head[31:0];
		end else if (ent_type == TLV_ANTENNA) begin
			dome_q = (ent_len == 8'd1 && pay_head[7:0] == 8'd0);
		end else if (ent_type == TLV_RANGE) begin
			if (ent_len >= RANGE_MIN_LEN) begin
				min_q = 29'(pay_head[31:0] / DECI_PER_METRE);
				max_q = 29'(pay_head[63:32] / DECI_PER_METRE);
			end
		end
	endfunction

	function automatic bit advance_parser(input logic [7:0] b, input logic fin,
			output caps_report_t rep);
		rep = '0;
		if (in_pay) begin
			if (pay_cnt < HEAD_BYTES)
				pay_head[8 * int'(pay_cnt) +: 8] = b;
			pay_cnt = pay_cnt + 8'd1;
			if (pay_cnt == ent_len) begin
				commit_entry();
				in_pay  = 1'b0;
				hdr_pos = HDR_TYPE;
			end
		end else begin
			case (hdr_pos)
				HDR_TYPE: begin
					ent_type = b;
					hdr_pos  = HDR_RSVD;
				end
				HDR_RSVD: hdr_pos = HDR_LEN;
				default: begin
					ent_len  = b;
					pay_cnt  = '0;
					pay_head = '0;
					hdr_pos  = HDR_TYPE;
					if (b == 8'd0)
						commit_entry();
					else
						in_pay = 1'b1;
				end
			endcase
		end
		if (!fin)
			return 1'b0;
		rep.status = in_pay;
		if (!in_pay)
			caps_ok = 1'b1;
		clear_parse();
		rep.caps_valid = caps_ok;
		rep.mode_mask  = mask_q;
		rep.dome       = dome_q;
		rep.min_m      = min_q;
		rep.max_m      = max_q;
		return 1'b1;
	endfunction

	function automatic caps_report_t mk_caps(input logic st, input logic cv,
			input logic [31:0] mask, input logic dome, input logic [28:0] mn,
			input logic [28:0] mx);
		caps_report_t r;
		r.status     = st;
		r.caps_valid = cv;
		r.mode_mask  = mask;
		r.dome       = dome;
		r.min_m      = mn;
		r.max_m      = mx;
		return r;
	endfunction

	function automatic dir_row_t dir_row(input logic [7:0] b, input logic fin,
			input logic typed, input caps_report_t want);
		dir_row_t r;
		r.data  = b;
		r.fin   = fin;
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 4))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'($urandom_range(0, 100000));
			default: return $urandom;
		endcase
	endfunction

	task automatic pick_entry(output logic [7:0] typ, output int len);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel <= 2) begin
			typ = TLV_MODES;
			len = ($urandom_range(0, 3) != 0) ? 4 : $urandom_range(0, 12);
		end else if (sel <= 4) begin
			typ = TLV_ANTENNA;
			len = ($urandom_range(0, 3) != 0) ? 1 : $urandom_range(0, 3);
		end else if (sel <= 7) begin
			typ = TLV_RANGE;
			len = ($urandom_range(0, 3) != 0) ? 8 : $urandom_range(0, 14);
		end else begin
			typ = 8'($urandom);
			len = $urandom_range(0, 20);
		end
		if ($urandom_range(0, 59) == 0)
			len = $urandom_range(200, 255);
	endtask

	task automatic push_entry(input logic [7:0] typ, input int len, input int keep);
		logic [31:0] w0;
		logic [31:0] w1;
		w0 = pick_word();
		w1 = pick_word();
		if (typ == TLV_ANTENNA && $urandom_range(0, 1) == 1)
			w0 = '0;
		rpt_bytes.push_back(typ);
		rpt_bytes.push_back(8'($urandom));
		rpt_bytes.push_back(8'(len));
		for (int i = 0; i < keep; i++) begin
			if (i < 4)
				rpt_bytes.push_back(w0[8 * i +: 8]);
			else if (i < 8)
				rpt_bytes.push_back(w1[8 * (i - 4) +: 8]);
			else
				rpt_bytes.push_back(8'($urandom));
		end
	endtask

	// mostly well-formed reports; some cut inside a payload or a header, some noise
	task automatic build_report();
		int         ending;
		int         len;
		logic [7:0] typ;
		rpt_bytes.delete();
		ending = $urandom_range(0, 9);
		if (ending == 0) begin
			repeat ($urandom_range(1, 24))
				rpt_bytes.push_back(8'($urandom));
			return;
		end
		repeat ($urandom_range(0, 4)) begin
			pick_entry(typ, len);
			push_entry(typ, len, len);
		end
		if (ending <= 2) begin
			pick_entry(typ, len);
			if (len == 0)
				len = 1;
			push_entry(typ, len, $urandom_range(0, len - 1));
		end else if (ending <= 4 || rpt_bytes.size() == 0) begin
			rpt_bytes.push_back(8'($urandom));
			if ($urandom_range(0, 1) == 1)
				rpt_bytes.push_back(8'($urandom));
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin, input int gap,
			input logic typed, input caps_report_t want);
		caps_report_t pred;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		report_byte <= b;
		last_byte   <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (advance_parser(b, fin, pred))
			expected_caps.push_back(typed ? want : pred);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_errs++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("radar_capability_tlv_parser_core_tb: done, errors");
		$finish;
	end

	initial begin : result_sink
		caps_report_t want;
		int           stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (expected_caps.size() == 0) begin
				$error("result with no report pending");
				n_errs++;
			end else begin
				want = expected_caps.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("capabilities_valid", 32'(want.caps_valid),
					32'(capabilities_valid));
				check_field("use_mode_mask", want.mode_mask, use_mode_mask);
				check_field("is_dome", 32'(want.dome), 32'(is_dome));
				check_field("min_range_meters", 32'(want.min_m), 32'(min_range_meters));
				check_field("max_range_meters", 32'(want.max_m), 32'(max_range_meters));
			end
		end
	end

	initial begin
		int sent;
		bit quiet;
		n_errs      = 0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		report_byte = '0;
		last_byte   = 1'b0;
		clear_parse();
		mask_q  = '0;
		dome_q  = 1'b0;
		min_q   = '0;
		max_q   = '0;
		caps_ok = 1'b0;

		// modes entry cut inside its payload, straight after reset
		dir_steps.push_back(dir_row(TLV_MODES, 1'b0, 1'b0, '0));
		dir_steps.push_back(dir_row(8'h00, 1'b0, 1'b0, '0));
		dir_steps.push_back(dir_row(MODES_MIN_LEN, 1'b0, 1'b0, '0));
		dir_steps.push_back(dir_row(8'hFF, 1'b1, 1'b1, mk_caps(1'b1, 1'b0, '0, 1'b0, '0, '0)));
		// dome entry, then full-scale range
		dir_steps.push_back(dir_row(TLV_ANTENNA, 1'b0, 1'b0, '0));
		dir_steps.push_back(dir_row(8'hFF, 1'b0, 1'b0, '0));
		dir_steps.push_back(dir_row(8'h01, 1'b0, 1'b0, '0));
		dir_steps.push_back(dir_row(8'h00, 1'b0, 1'b0, '0));
		dir_steps.push_back(dir_row(TLV_RANGE, 1'b0, 1'b0, '0));
		dir_steps.push_back(dir_row(8'h00, 1'b0, 1'b0, '0));
		dir_steps.push_back(dir_row(RANGE_MIN_LEN, 1'b0, 1'b0, '0));
		repeat (7)
			dir_steps.push_back(dir_row(8'hFF, 1'b0, 1'b0, '0));
		dir_steps.push_back(dir_row(8'hFF, 1'b1, 1'b1,
			mk_caps(1'b0, 1'b1, '0, 1'b1, RANGE_TOP, RANGE_TOP)));
		// empty antenna entry clears dome; report ends inside the next header
		dir_steps.push_back(dir_row(TLV_ANTENNA, 1'b0, 1'b0, '0));
		dir_steps.push_back(dir_row(8'h00, 1'b0, 1'b0, '0));
		dir_steps.push_back(dir_row(8'h00, 1'b0, 1'b0, '0));
		dir_steps.push_back(dir_row(TLV_MODES, 1'b1, 1'b1,
			mk_caps(1'b0, 1'b1, '0, 1'b0, RANGE_TOP, RANGE_TOP)));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_steps[i])
			send_byte(dir_steps[i].data, dir_steps[i].fin, $urandom_range(0, 16),
				dir_steps[i].typed, dir_steps[i].want);

		sent = 0;
		while (sent < RAND_BYTES) begin
			build_report();
			quiet = ($urandom_range(0, 3) == 0);
			foreach (rpt_bytes[i])
				send_byte(rpt_bytes[i], i == rpt_bytes.size() - 1,
					quiet ? 0 : $urandom_range(0, 16), 1'b0, '0);
			sent += rpt_bytes.size();
		end
		in_valid <= 1'b0;

		while (expected_caps.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errs == 0)
			$display("radar_capability_tlv_parser_core_tb: done, clean");
		else
			$display("radar_capability_tlv_parser_core_tb: done, errors");
		$finish;
	end

endmodule
